FILE: hdl/binary_min_heap_queue_top_defines.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_defines
// Assertion macros used by the heap queue top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset
`define BMHQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define BMHQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, constants and codes shared by the heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W   = 31;
  localparam int ID_W    = 16;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused code, reports state only

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOT_LT  = 3'd3;
  localparam logic [2:0] ST_BAD_POS = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] item_key;
    logic [ID_W-1:0]  item_id;
    logic [POS_W-1:0] heap_position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    removed_id;
    logic [KEY_W-1:0]   removed_key;
    logic [ID_W-1:0]    min_id;
    logic [KEY_W-1:0]   min_key;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_FETCH, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
    S_ROOT_RD, S_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch input item
    logic start;      // classify, update count, read root and target slot
    logic fetch;      // take target slot data
    logic up_rd;      // read parent, or park entry at the root
    logic up_cmp;     // compare with parent, move one of the two
    logic dn_rd;      // read children, or park entry at a leaf
    logic dn_cmp;     // compare with children, move one of the two
    logic root_rd;    // read root for result
    logic finish;     // register result
  } cmd_t;

  typedef struct packed {
    logic up_go;
    logic dn_go;
    logic at_root;
    logic up_swap;
    logic has_child;
    logic dn_swap;
  } sts_t;

endpackage

FILE: hdl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Operation sequencer: walks sift-up or sift-down one level at a time, a read state then a compare state per level.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  input  bmhq_pkg::sts_t  sts,
  output bmhq_pkg::cmd_t  cmd,
  output logic            idle
);

  bmhq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bmhq_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmhq_pkg::S_IDLE:    if (in_fire) state_next = bmhq_pkg::S_START;
      bmhq_pkg::S_START:   state_next = bmhq_pkg::S_FETCH;
      bmhq_pkg::S_FETCH: begin
        if (sts.up_go)      state_next = bmhq_pkg::S_UP_RD;
        else if (sts.dn_go) state_next = bmhq_pkg::S_DN_RD;
        else                state_next = bmhq_pkg::S_ROOT_RD;
      end
      bmhq_pkg::S_UP_RD:
        state_next = sts.at_root ? bmhq_pkg::S_ROOT_RD : bmhq_pkg::S_UP_CMP;
      bmhq_pkg::S_UP_CMP:
        state_next = sts.up_swap ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_ROOT_RD;
      bmhq_pkg::S_DN_RD:
        state_next = sts.has_child ? bmhq_pkg::S_DN_CMP : bmhq_pkg::S_ROOT_RD;
      bmhq_pkg::S_DN_CMP:
        state_next = sts.dn_swap ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_ROOT_RD;
      bmhq_pkg::S_ROOT_RD: state_next = bmhq_pkg::S_RESULT;
      bmhq_pkg::S_RESULT:  if (!out_busy) state_next = bmhq_pkg::S_IDLE;
      default:             state_next = bmhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state)
      bmhq_pkg::S_IDLE:    begin idle = 1'b1; cmd.load = in_fire; end
      bmhq_pkg::S_START:   cmd.start = 1'b1;
      bmhq_pkg::S_FETCH:   cmd.fetch = 1'b1;
      bmhq_pkg::S_UP_RD:   cmd.up_rd = 1'b1;
      bmhq_pkg::S_UP_CMP:  cmd.up_cmp = 1'b1;
      bmhq_pkg::S_DN_RD:   cmd.dn_rd = 1'b1;
      bmhq_pkg::S_DN_CMP:  cmd.dn_cmp = 1'b1;
      bmhq_pkg::S_ROOT_RD: cmd.root_rd = 1'b1;
      bmhq_pkg::S_RESULT:  cmd.finish = !out_busy;
      default:             ;
    endcase
  end

endmodule

FILE: hdl/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap storage (one key/id memory) with the sift datapath.
// The moving entry stays in a register while its hole walks the heap;
// each step writes either the neighbor or the moving entry into the hole.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bmhq_pkg::cmd_t      cmd,
  input  bmhq_pkg::in_item_t  in_item,
  output bmhq_pkg::sts_t      sts,
  output bmhq_pkg::out_item_t res,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int KW = bmhq_pkg::KEY_W;
  localparam int IW = bmhq_pkg::ID_W;
  localparam int EW = KW + IW;

  logic [EW-1:0] mem [CAPACITY];

  logic [1:0]                 kind;
  logic [KW-1:0]              ikey;
  logic [IW-1:0]              iid;
  logic [bmhq_pkg::POS_W-1:0] ipos;

  logic [AW-1:0]  pos;      // hole of the moving entry
  logic [EW-1:0]  cur;      // moving entry value
  logic [EW-1:0]  rd_a, rd_b;
  logic [AW-1:0]  ra_a, ra_b;
  logic           re;
  logic           we;
  logic [EW-1:0]  wd;
  logic [2:0]     status;
  logic [EW-1:0]  removed;
  logic           go_up, go_dn;

  logic [AW:0]    lch;      // one bit wider than a slot index
  logic [AW:0]    rch;
  logic [AW-1:0]  par;
  logic           l_ok, r_ok;
  logic           at_root, up_swap, dec_fail;
  logic           l_lt, r_lt, dn_swap;
  logic [KW-1:0]  lt_key;
  logic [EW-1:0]  best_e;
  logic [AW-1:0]  best_p;

  function automatic logic [KW-1:0] key_of(input logic [EW-1:0] e);
    return e[EW-1 -: KW];
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[pos] <= wd;
    if (re) begin
      rd_a <= mem[ra_a];
      rd_b <= mem[ra_b];
    end
  end

  assign lch = {pos, 1'b1};
  assign rch = lch + (AW+1)'(1);
  assign par = (pos - AW'(1)) >> 1;
  assign l_ok = (lch < (AW+1)'(count));
  assign r_ok = (rch < (AW+1)'(count));

  assign at_root  = (pos == '0);
  assign up_swap  = (key_of(rd_a) > key_of(cur));
  assign dec_fail = (kind == bmhq_pkg::KIND_DEC) && (key_of(rd_b) <= ikey);

  // right child wins only when smaller than the winner so far
  assign l_lt   = l_ok && (key_of(rd_a) < key_of(cur));
  assign lt_key = l_lt ? key_of(rd_a) : key_of(cur);
  assign r_lt   = r_ok && (key_of(rd_b) < lt_key);
  assign dn_swap = l_lt || r_lt;
  assign best_e  = r_lt ? rd_b : rd_a;
  assign best_p  = r_lt ? rch[AW-1:0] : lch[AW-1:0];

  // read address selection
  always_comb begin
    re   = 1'b0;
    ra_a = '0;
    ra_b = '0;
    if (cmd.start) begin
      re = 1'b1;
      case (kind)
        bmhq_pkg::KIND_DEQ: ra_b = AW'(count - CW'(1));
        bmhq_pkg::KIND_DEC: ra_b = AW'(ipos);
        default:            ra_b = '0;
      endcase
    end else if (cmd.up_rd) begin
      re = 1'b1; ra_a = par;
    end else if (cmd.dn_rd) begin
      re = 1'b1; ra_a = lch[AW-1:0]; ra_b = rch[AW-1:0];
    end else if (cmd.root_rd) begin
      re = 1'b1;
    end
  end

  // write into the hole
  always_comb begin
    we = 1'b0;
    wd = cur;
    if (cmd.up_rd && at_root) begin
      we = 1'b1;
    end else if (cmd.up_cmp) begin
      we = 1'b1;
      if (up_swap) wd = rd_a;
    end else if (cmd.dn_rd && !l_ok) begin
      we = 1'b1;
    end else if (cmd.dn_cmp) begin
      we = 1'b1;
      if (dn_swap) wd = best_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      status  <= bmhq_pkg::ST_OK;
      removed <= '0;
      go_up   <= 1'b0;
      go_dn   <= 1'b0;
    end else begin
      if (cmd.start) begin
        status  <= bmhq_pkg::ST_OK;
        removed <= '0;
        go_up   <= 1'b0;
        go_dn   <= 1'b0;
        case (kind)
          bmhq_pkg::KIND_ENQ: begin
            if (count == CW'(CAPACITY)) status <= bmhq_pkg::ST_FULL;
            else begin
              go_up <= 1'b1; count <= count + CW'(1);
            end
          end
          bmhq_pkg::KIND_DEQ: begin
            if (count == '0) status <= bmhq_pkg::ST_EMPTY;
            else begin
              go_dn <= 1'b1; count <= count - CW'(1);
            end
          end
          bmhq_pkg::KIND_DEC: begin
            if (32'(ipos) >= 32'(count)) status <= bmhq_pkg::ST_BAD_POS;
            else go_up <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.fetch) begin
        if (go_dn) removed <= rd_a;
        if (go_up && dec_fail) status <= bmhq_pkg::ST_NOT_LT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_item.kind;
      ikey <= in_item.item_key;
      iid  <= in_item.item_id;
      ipos <= in_item.heap_position;
    end
    if (cmd.start) begin
      cur <= {ikey, iid};
      if (kind == bmhq_pkg::KIND_DEQ)      pos <= '0;
      else if (kind == bmhq_pkg::KIND_DEC) pos <= AW'(ipos);
      else                                 pos <= AW'(count);
    end
    // rd_b holds the last entry for dequeue, the target slot for decrease
    if (cmd.fetch) begin
      if (kind == bmhq_pkg::KIND_DEQ)      cur <= rd_b;
      else if (kind == bmhq_pkg::KIND_DEC) cur <= {ikey, rd_b[IW-1:0]};
    end
    if (cmd.up_cmp && up_swap) pos <= par;
    if (cmd.dn_cmp && dn_swap) pos <= best_p;
  end

  assign sts.up_go     = go_up && !dec_fail;
  assign sts.dn_go     = go_dn;
  assign sts.at_root   = at_root;
  assign sts.up_swap   = up_swap;
  assign sts.has_child = l_ok;
  assign sts.dn_swap   = dn_swap;

  // rd_a holds the root after the root read
  always_comb begin
    res = '0;
    res.status      = status;
    res.removed_id  = removed[IW-1:0];
    res.removed_key = key_of(removed);
    if (count != '0) begin
      res.min_id  = rd_a[IW-1:0];
      res.min_key = key_of(rd_a);
    end
    res.entry_count = bmhq_pkg::COUNT_W'(count);
    res.is_empty    = (count == '0);
  end

endmodule

FILE: hdl/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap priority queue with enqueue, dequeue and decrease-key.
// ----------------------------------------------------------------------------
// One operation at a time. An operation that fails or changes nothing goes
// from its start and fetch steps straight to the root read and the result;
// any other first walks the moving entry up or down the heap one level at
// a time, with one registered read of the heap memory per level. The
// result is held in an output register; a finished operation waits only
// while an earlier result is still not taken, and the next item is accepted
// in the cycle after its result is registered.
`include "binary_min_heap_queue_top_defines.svh"
module binary_min_heap_queue_top #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmhq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmhq_pkg::out_item_t out_data
);

  bmhq_pkg::cmd_t      cmd;
  bmhq_pkg::sts_t      sts;
  bmhq_pkg::out_item_t res;
  logic                idle;
  logic [$clog2(CAPACITY+1)-1:0] count;
  logic                in_fire;

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  bmhq_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_busy(out_valid && !out_ready),
    .sts, .cmd, .idle
  );

  bmhq_dp #(.CAPACITY(CAPACITY))
  u_dp (
    .clk, .rst, .cmd, .in_item(in_data), .sts, .res, .count
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= res;
  end

  `BMHQ_ASSERT_IMP(a_no_overfill, clk, rst, 1'b1, count <= CAPACITY, "count above capacity")
  `BMHQ_ASSERT_NXT(a_finish_valid, clk, rst, cmd.finish, out_valid, "result not presented")
  `BMHQ_ASSERT_IMP(a_empty_flag, clk, rst, cmd.finish, res.is_empty == (count == 0), "empty flag mismatch")

endmodule

FILE: dv/heap_queue_checker.sv
// ----------------------------------------------------------------------------
// heap_queue_checker
// Watches both channels of the heap queue, keeps its own copy of the heap,
// works out the result of every accepted operation and compares each result
// transfer field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module heap_queue_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bmhq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bmhq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  fill_now
);

  localparam int SLOTS = bmhq_pkg::CAPACITY_DEF;

  logic [bmhq_pkg::KEY_W-1:0] shadow_keys [SLOTS];
  logic [bmhq_pkg::ID_W-1:0]  shadow_ids  [SLOTS];
  int                         shadow_fill = 0;
  bmhq_pkg::out_item_t        expected_results [$];

  function automatic void swap_entries(int a, int b);
    logic [bmhq_pkg::KEY_W-1:0] k;
    logic [bmhq_pkg::ID_W-1:0]  d;
    k = shadow_keys[a];
    d = shadow_ids[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_ids[a]  = shadow_ids[b];
    shadow_keys[b] = k;
    shadow_ids[b]  = d;
  endfunction

  function automatic void bubble_up(int pos);
    int parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (shadow_keys[parent] <= shadow_keys[pos]) break;
      swap_entries(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int lc, rc, best;
    while (pos < shadow_fill) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < shadow_fill && shadow_keys[lc] < shadow_keys[best]) best = lc;
      if (rc < shadow_fill && shadow_keys[rc] < shadow_keys[best]) best = rc;
      if (best == pos) break;
      swap_entries(pos, best);
      pos = best;
    end
  endfunction

  function automatic bmhq_pkg::out_item_t apply_heap_op(bmhq_pkg::in_item_t op);
    bmhq_pkg::out_item_t r;
    r = '0;
    r.status = bmhq_pkg::ST_OK;
    case (op.kind)
      bmhq_pkg::KIND_ENQ: begin
        if (shadow_fill >= SLOTS) r.status = bmhq_pkg::ST_FULL;
        else begin
          shadow_keys[shadow_fill] = op.item_key;
          shadow_ids[shadow_fill]  = op.item_id;
          shadow_fill++;
          bubble_up(shadow_fill - 1);
        end
      end
      bmhq_pkg::KIND_DEQ: begin
        if (shadow_fill == 0) r.status = bmhq_pkg::ST_EMPTY;
        else begin
          r.removed_key = shadow_keys[0];
          r.removed_id  = shadow_ids[0];
          swap_entries(0, shadow_fill - 1);
          shadow_fill--;
          bubble_down(0);
        end
      end
      bmhq_pkg::KIND_DEC: begin
        if (int'(op.heap_position) >= shadow_fill) r.status = bmhq_pkg::ST_BAD_POS;
        else if (shadow_keys[op.heap_position] <= op.item_key)
          r.status = bmhq_pkg::ST_NOT_LT;
        else begin
          shadow_keys[op.heap_position] = op.item_key;
          bubble_up(int'(op.heap_position));
        end
      end
      default: ;
    endcase
    if (shadow_fill > 0) begin
      r.min_id  = shadow_ids[0];
      r.min_key = shadow_keys[0];
    end
    r.entry_count = bmhq_pkg::COUNT_W'(shadow_fill);
    r.is_empty    = (shadow_fill == 0);
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bmhq_pkg::out_item_t want;
    if (rst) begin
      shadow_fill = 0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_heap_op(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status",      want.status,      out_data.status);
          compare_field("removed_id",  want.removed_id,  out_data.removed_id);
          compare_field("removed_key", want.removed_key, out_data.removed_key);
          compare_field("min_id",      want.min_id,      out_data.min_id);
          compare_field("min_key",     want.min_key,     out_data.min_key);
          compare_field("entry_count", want.entry_count, out_data.entry_count);
          compare_field("is_empty",    want.is_empty,    out_data.is_empty);
        end
      end
    end
    pending_count = expected_results.size();
    fill_now      = shadow_fill;
  end
endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the heap queue with directed corner cases, a fill-to-full run,
// a long drain and random mixes of operations with random gaps on both
// channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bmhq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bmhq_pkg::out_item_t out_data;
  int                  fail_count, pending_count, fill_now;
  bit                  hold_off = 1'b0;
  int                  ops_sent = 0;
  int                  results_seen = 0;
  int                  idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  binary_min_heap_queue_top dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  heap_queue_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending_count, .fill_now
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // one operation: offer it, hold until transfer, then an optional gap
  task automatic send_op(logic [1:0] kind, logic [bmhq_pkg::KEY_W-1:0] key,
                         logic [bmhq_pkg::ID_W-1:0] id,
                         logic [bmhq_pkg::POS_W-1:0] pos, bit gaps);
    int g;
    in_data  <= '{kind: kind, item_key: key, item_id: id, heap_position: pos};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return bmhq_pkg::KEY_W'($urandom_range(0, 40));
      default: return bmhq_pkg::KEY_W'($urandom());
    endcase
  endfunction

  function automatic logic [bmhq_pkg::POS_W-1:0] rand_pos();
    if (fill_now > 0 && $urandom_range(0, 7) != 0)
      return bmhq_pkg::POS_W'($urandom_range(0, fill_now - 1));
    return bmhq_pkg::POS_W'($urandom());
  endfunction

  task automatic random_op(int enq_w, int deq_w);
    int r;
    logic [1:0] kind;
    r = $urandom_range(0, 99);
    if (r < enq_w) kind = bmhq_pkg::KIND_ENQ;
    else if (r < enq_w + deq_w) kind = bmhq_pkg::KIND_DEQ;
    else if (r < 97) kind = bmhq_pkg::KIND_DEC;
    else kind = bmhq_pkg::KIND_NONE;
    send_op(kind, rand_key(), bmhq_pkg::ID_W'($urandom()), rand_pos(), 1'b1);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, every kind
    send_op(bmhq_pkg::KIND_DEQ, '0, '0, '0, 1'b0);
    send_op(bmhq_pkg::KIND_DEC, '0, '0, '0, 1'b0);
    send_op(bmhq_pkg::KIND_NONE, '1, '1, '1, 1'b0);
    send_op(bmhq_pkg::KIND_ENQ, '1, '1, '1, 1'b0);
    send_op(bmhq_pkg::KIND_DEC, '1, '0, '0, 1'b0);
    send_op(bmhq_pkg::KIND_ENQ, '0, '0, '0, 1'b0);
    send_op(bmhq_pkg::KIND_ENQ, bmhq_pkg::KEY_W'(500), 16'h5555, '0, 1'b0);
    send_op(bmhq_pkg::KIND_ENQ, bmhq_pkg::KEY_W'(500), 16'hAAAA, '0, 1'b0);
    send_op(bmhq_pkg::KIND_DEC, bmhq_pkg::KEY_W'(500), '0, bmhq_pkg::POS_W'(2), 1'b0);
    send_op(bmhq_pkg::KIND_DEC, bmhq_pkg::KEY_W'(7), '0, bmhq_pkg::POS_W'(3), 1'b0);
    send_op(bmhq_pkg::KIND_DEC, '0, '0, bmhq_pkg::POS_W'(3), 1'b0);
    send_op(bmhq_pkg::KIND_DEC, '0, '0, '1, 1'b0);
    send_op(bmhq_pkg::KIND_NONE, bmhq_pkg::KEY_W'(1), '0, '0, 1'b0);
    repeat (5) send_op(bmhq_pkg::KIND_DEQ, '0, '0, '0, 1'b0);
    drop_valid();

    // long receiver hold-off while offering items: the block must stall input
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_op(bmhq_pkg::KIND_ENQ, rand_key(), bmhq_pkg::ID_W'($urandom()),
                          '0, 1'b0);
    join
    drop_valid();
    // sender pause until every result is in
    while (pending_count != 0) @(posedge clk);

    // fill to capacity, overflow, decrease keys at full, then a long drain
    repeat (1030) send_op(bmhq_pkg::KIND_ENQ, rand_key(), bmhq_pkg::ID_W'($urandom()),
                          '0, $urandom_range(0, 30) == 0);
    repeat (40) random_op(0, 0);
    repeat (600) send_op(bmhq_pkg::KIND_DEQ, '0, '0, '0, $urandom_range(0, 30) == 0);
    drop_valid();
    while (pending_count != 0) @(posedge clk);

    // random mix
    repeat (140) random_op(40, 30);
    drop_valid();

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d operations (fill to full, long drain, random mixes),",
             ops_sent);
    $display("checked %0d results.", results_seen);
    if (fail_count == 0 && pending_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_dp.sv
hdl/binary_min_heap_queue_top.sv
dv/heap_queue_checker.sv
dv/tb_top.sv
